@@ src/mfv_pkg.sv @@
// Shared types and constants for the message frame validator.
// No dependencies; used by every module of the block by scoped name.
`default_nettype none

package mfv_pkg;

  // Largest frame length accepted, in bytes
  localparam int unsigned MaxFrameBytes = 65535;
  localparam int unsigned LenCmpW = 20;
  localparam logic [LenCmpW-1:0] MAX_FRAME_LEN = LenCmpW'(MaxFrameBytes);

  // Trailing end-marker bytes at the tail of the body
  localparam logic [15:0] END_MARKER_BYTES = 16'd4;

  // Reset value of the header length register
  localparam logic [7:0] HEADER_LENGTH_RESET = 8'd24;

  // Item kinds
  localparam logic CMD_HEADER = 1'b0;
  localparam logic CMD_BODY   = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_START_MAGIC   = 2'd0;
  localparam logic [1:0] REG_END_MAGIC     = 2'd1;
  localparam logic [1:0] REG_HEADER_LENGTH = 2'd2;

  // Verdict codes, first failure wins
  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_START = 3'd1,
    ST_SIZE  = 3'd2,
    ST_END   = 3'd3,
    ST_SUM   = 3'd4,
    ST_SHORT = 3'd5
  } status_t;

  // One input item as held in the input register
  typedef struct packed {
    logic        cmd;
    logic [31:0] header_start_marker;
    logic [31:0] declared_size;
    logic [31:0] sender_checksum;
    logic [15:0] frame_length;
    logic [7:0]  body_byte;
  } item_t;

endpackage

`default_nettype wire

@@ src/message_frame_validator_core.sv @@
// Top level of the message frame validator.
// Depends on mfv_pkg, mfv_in_stage and mfv_check.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item per transfer: a
//   header (cmd 0) with start marker, declared size, sender checksum and
//   frame length, or a body byte (cmd 1). Body bytes are the payload,
//   which feeds a rotate-left-then-add checksum, followed by four
//   end-marker bytes, least significant first.
//   Output channel (out_valid/out_ready) carries one verdict per frame:
//   frame_ok, status (first failure) and computed_checksum. A header whose
//   length cannot hold the header and end marker yields status 5 at once.
//   Configuration channel (cfg_valid/cfg_ready) writes start magic, end
//   magic and header length by index; cfg_ready is always high.
//   Throughput is one item per cycle while the verdict side does not stall.
//   The deciding item is held in the input register and passes through the
//   state update into the result register, which raises out_valid.
//   While the receiver stalls with a verdict pending, one more item of any
//   kind is held in the input register and in_ready stays low until the
//   verdict transfers. Reset clears the frame state, empties both
//   registers and restores the configuration defaults.
`default_nettype none

module message_frame_validator_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        cmd,
  input  wire logic [31:0] header_start_marker,
  input  wire logic [31:0] declared_size,
  input  wire logic [31:0] sender_checksum,
  input  wire logic [15:0] frame_length,
  input  wire logic [7:0]  body_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             frame_ok,
  output logic [2:0]       status,
  output logic [31:0]      computed_checksum
);

  mfv_pkg::item_t in_item;
  mfv_pkg::item_t item;
  logic           item_valid;
  logic           take;

  assign cfg_ready = 1'b1;

  // Gather the payload ports into one item
  always_comb begin
    in_item.cmd                 = cmd;
    in_item.header_start_marker = header_start_marker;
    in_item.declared_size       = declared_size;
    in_item.sender_checksum     = sender_checksum;
    in_item.frame_length        = frame_length;
    in_item.body_byte           = body_byte;
  end

  mfv_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  mfv_check u_check (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .item_valid        (item_valid),
    .item              (item),
    .take              (take),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .frame_ok          (frame_ok),
    .status            (status),
    .computed_checksum (computed_checksum)
  );

endmodule

`default_nettype wire

@@ src/mfv_in_stage.sv @@
// Input register of the message frame validator.
// Depends on mfv_pkg for the item type.
`default_nettype none

module mfv_in_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire mfv_pkg::item_t in_item,
  input  wire logic          take,
  output logic               item_valid,
  output mfv_pkg::item_t     item
);

  // Refill the register whenever it is empty or drained this cycle
  assign in_ready = !item_valid || take;

  // Hold valid until the checker takes the item
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  // Capture payload on each transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

@@ src/mfv_check.sv @@
// Frame state, checksum, end marker assembly and verdict register.
// Depends on mfv_pkg for the item type, status codes and constants.
`default_nettype none

module mfv_check (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_valid,
  input  wire logic [1:0]     cfg_index,
  input  wire logic [31:0]    cfg_data,
  input  wire logic           item_valid,
  input  wire mfv_pkg::item_t item,
  output logic                take,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic                frame_ok,
  output logic [2:0]          status,
  output logic [31:0]         computed_checksum
);

  logic [31:0] start_magic;
  logic [31:0] end_magic;
  logic [7:0]  header_length;

  logic            in_body, in_body_next;
  logic [15:0]     bytes_left, bytes_left_next;
  logic [31:0]     running_sum, running_sum_next;
  logic [31:0]     end_marker_shift, end_marker_shift_next;
  logic [31:0]     expected_sum, expected_sum_next;
  mfv_pkg::status_t header_fault, header_fault_next;

  logic             fire;
  mfv_pkg::status_t res_status;
  logic [31:0]      res_sum;
  logic [16:0]      min_len;
  logic             too_short;
  logic             too_long;

  // Write configuration registers; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      start_magic   <= '0;
      end_magic     <= '0;
      header_length <= mfv_pkg::HEADER_LENGTH_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mfv_pkg::REG_START_MAGIC:   start_magic   <= cfg_data;
        mfv_pkg::REG_END_MAGIC:     end_magic     <= cfg_data;
        mfv_pkg::REG_HEADER_LENGTH: header_length <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Take the held item when the result register can be loaded
  assign take = item_valid && (!out_valid || out_ready);

  assign min_len   = {9'd0, header_length} + {1'b0, mfv_pkg::END_MARKER_BYTES};
  assign too_short = {1'b0, item.frame_length} < min_len;
  assign too_long  = {4'd0, item.frame_length} > mfv_pkg::MAX_FRAME_LEN;

  // Advance frame state for one item
  always_comb begin
    in_body_next          = in_body;
    bytes_left_next       = bytes_left;
    running_sum_next      = running_sum;
    end_marker_shift_next = end_marker_shift;
    expected_sum_next     = expected_sum;
    header_fault_next     = header_fault;
    fire                  = 1'b0;
    res_status            = mfv_pkg::ST_OK;
    res_sum               = '0;
    if (take) begin
      if (item.cmd == mfv_pkg::CMD_HEADER) begin
        in_body_next          = 1'b0;
        running_sum_next      = '0;
        end_marker_shift_next = '0;
        if (too_short || too_long) begin
          bytes_left_next   = '0;
          header_fault_next = mfv_pkg::ST_OK;
          fire              = 1'b1;
          res_status        = mfv_pkg::ST_SHORT;
        end else begin
          in_body_next      = 1'b1;
          bytes_left_next   = item.frame_length - {8'd0, header_length};
          expected_sum_next = item.sender_checksum;
          if (item.header_start_marker != start_magic) begin
            header_fault_next = mfv_pkg::ST_START;
          end else if (item.declared_size != {16'd0, item.frame_length}) begin
            header_fault_next = mfv_pkg::ST_SIZE;
          end else begin
            header_fault_next = mfv_pkg::ST_OK;
          end
        end
      end else if (in_body) begin
        // Payload feeds the checksum, the tail feeds the end marker
        if (bytes_left > mfv_pkg::END_MARKER_BYTES) begin
          running_sum_next = {running_sum[30:0], running_sum[31]} + {24'd0, item.body_byte};
        end else begin
          end_marker_shift_next = {item.body_byte, end_marker_shift[31:8]};
        end
        bytes_left_next = bytes_left - 16'd1;
        if (bytes_left_next == '0) begin
          in_body_next = 1'b0;
          fire         = 1'b1;
          res_sum      = running_sum_next;
          if (header_fault != mfv_pkg::ST_OK) begin
            res_status = header_fault;
          end else if (end_marker_shift_next != end_magic) begin
            res_status = mfv_pkg::ST_END;
          end else if (running_sum_next != expected_sum) begin
            res_status = mfv_pkg::ST_SUM;
          end else begin
            res_status = mfv_pkg::ST_OK;
          end
        end
      end
    end
  end

  // Frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_body          <= 1'b0;
      bytes_left       <= '0;
      running_sum      <= '0;
      end_marker_shift <= '0;
      expected_sum     <= '0;
      header_fault     <= mfv_pkg::ST_OK;
    end else begin
      in_body          <= in_body_next;
      bytes_left       <= bytes_left_next;
      running_sum      <= running_sum_next;
      end_marker_shift <= end_marker_shift_next;
      expected_sum     <= expected_sum_next;
      header_fault     <= header_fault_next;
    end
  end

  // Result register: load on a verdict, drop after the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      frame_ok          <= (res_status == mfv_pkg::ST_OK);
      status            <= res_status;
      computed_checksum <= res_sum;
    end
  end

  // An open frame always has bytes still to come
  a_open_has_bytes: assert property (@(posedge clk) disable iff (rst)
    in_body |-> (bytes_left != '0))
    else $error("open frame with no bytes left");

  // The last body byte of an open frame yields a verdict
  a_last_byte_verdict: assert property (@(posedge clk) disable iff (rst)
    (take && item.cmd == mfv_pkg::CMD_BODY && in_body && bytes_left == 16'd1)
      |=> out_valid)
    else $error("last body byte gave no verdict");

  // frame_ok agrees with the status code
  a_ok_matches_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (frame_ok == (status == mfv_pkg::ST_OK)))
    else $error("frame_ok disagrees with status");

  // Short frames report a zero checksum
  a_short_zero_sum: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == mfv_pkg::ST_SHORT) |-> (computed_checksum == '0))
    else $error("short frame with nonzero checksum");

endmodule

`default_nettype wire

@@ verif/mfv_frame_checker.sv @@
// Checker for the message frame validator: watches the config, input and
// verdict channels, predicts each verdict and compares it field by field.
// Depends on mfv_pkg for the register indexes, item kinds and status codes.
module mfv_frame_checker
  import mfv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        cmd,
  input  logic [31:0] header_start_marker,
  input  logic [31:0] declared_size,
  input  logic [31:0] sender_checksum,
  input  logic [15:0] frame_length,
  input  logic [7:0]  body_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        frame_ok,
  input  logic [2:0]  status,
  input  logic [31:0] computed_checksum,
  output int          fail_count,
  output int          pending,
  output int          verdict_count,
  output logic [5:0]  status_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxReported = 10;

  typedef struct packed {
    logic        ok;
    status_t     code;
    logic [31:0] sum;
  } verdict_t;

  // Predicted verdicts, oldest first
  verdict_t verdict_q[$];

  // Register copies
  logic [31:0] start_word;
  logic [31:0] end_word;
  logic [7:0]  hdr_len;

  // Frame tracking
  logic        frame_open;
  logic [15:0] body_left;
  logic [31:0] csum;
  logic [31:0] tail_word;
  logic [31:0] sender_sum;
  status_t     hdr_fault;

  always @(posedge clk) begin
    verdict_t want;
    status_t  code;
    if (rst) begin
      start_word    = '0;
      end_word      = '0;
      hdr_len       = HEADER_LENGTH_RESET;
      frame_open    = 1'b0;
      body_left     = '0;
      csum          = '0;
      tail_word     = '0;
      sender_sum    = '0;
      hdr_fault     = ST_OK;
      fail_count    = 0;
      verdict_count = 0;
      status_seen   = '0;
      verdict_q.delete();
    end else begin
      // Compare a delivered verdict against the oldest prediction
      if (out_valid && out_ready) begin
        verdict_count++;
        if (status <= 3'(ST_SHORT)) status_seen[status] = 1'b1;
        if (verdict_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MaxReported)
            $display("[%0t] unexpected verdict: ok=%0b status=%0d sum=%h",
                     $time, frame_ok, status, computed_checksum);
        end else begin
          want = verdict_q.pop_front();
          if (frame_ok !== want.ok || status !== want.code ||
              computed_checksum !== want.sum) begin
            fail_count++;
            if (fail_count <= MaxReported)
              $display("[%0t] verdict mismatch: want ok=%0b status=%0d sum=%h, got ok=%0b status=%0d sum=%h",
                       $time, want.ok, want.code, want.sum,
                       frame_ok, status, computed_checksum);
          end
        end
      end

      // Track register writes; indexes past the last register are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_START_MAGIC:   start_word = cfg_data;
          REG_END_MAGIC:     end_word   = cfg_data;
          REG_HEADER_LENGTH: hdr_len    = cfg_data[7:0];
          default: ;
        endcase
      end

      // Advance the frame state on each input transfer
      if (in_valid && in_ready) begin
        if (cmd == CMD_HEADER) begin
          // A header always abandons whatever frame was open
          frame_open = 1'b0;
          csum       = '0;
          tail_word  = '0;
          if ({16'd0, frame_length} < {24'd0, hdr_len} + 32'd4 ||
              {16'd0, frame_length} > MaxFrameBytes) begin
            body_left = '0;
            hdr_fault = ST_OK;
            want = '{1'b0, ST_SHORT, 32'd0};
            verdict_q.push_back(want);
          end else begin
            frame_open = 1'b1;
            body_left  = frame_length - {8'd0, hdr_len};
            sender_sum = sender_checksum;
            if (header_start_marker != start_word)
              hdr_fault = ST_START;
            else if (declared_size != {16'd0, frame_length})
              hdr_fault = ST_SIZE;
            else
              hdr_fault = ST_OK;
          end
        end else if (frame_open) begin
          // Payload bytes feed the checksum, the last four build the end marker
          if (body_left > END_MARKER_BYTES)
            csum = {csum[30:0], csum[31]} + {24'd0, body_byte};
          else
            tail_word = {body_byte, tail_word[31:8]};
          body_left = body_left - 16'd1;
          if (body_left == 16'd0) begin
            frame_open = 1'b0;
            if (hdr_fault != ST_OK)
              code = hdr_fault;
            else if (tail_word != end_word)
              code = ST_END;
            else if (csum != sender_sum)
              code = ST_SUM;
            else
              code = ST_OK;
            want = '{code == ST_OK, code, csum};
            verdict_q.push_back(want);
          end
        end
      end
    end
    pending = verdict_q.size();
  end

endmodule

@@ verif/message_frame_validator_core_tb.sv @@
// Testbench top for message_frame_validator_core: drives frames, noise and
// register settings, stalls the verdict side, and reports the verdict.
// Depends on mfv_pkg, the block itself and mfv_frame_checker.
module message_frame_validator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mfv_pkg::*;

  localparam logic [1:0] REG_SPARE      = 2'd3;
  localparam logic [3:0] FAULT_START    = 4'b0001;
  localparam logic [3:0] FAULT_SIZE     = 4'b0010;
  localparam logic [3:0] FAULT_END      = 4'b0100;
  localparam logic [3:0] FAULT_SUM      = 4'b1000;
  localparam int         DRAIN_CYCLES   = 4;
  localparam int         LONG_HOLD      = 200;
  localparam int         WATCHDOG_LIMIT = 1000;
  localparam int         PHASE_ITEMS    = 220;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        cmd = CMD_HEADER;
  logic [31:0] header_start_marker = '0;
  logic [31:0] declared_size = '0;
  logic [31:0] sender_checksum = '0;
  logic [15:0] frame_length = '0;
  logic [7:0]  body_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        frame_ok;
  logic [2:0]  status;
  logic [31:0] computed_checksum;

  int          fail_count;
  int          pending;
  int          verdict_count;
  logic [5:0]  status_seen;

  // Stimulus bookkeeping
  logic [31:0] cur_start = '0;
  logic [31:0] cur_end = '0;
  logic [7:0]  cur_hlen = HEADER_LENGTH_RESET;
  bit          src_idle_en = 1'b1;
  bit          sink_idle_en = 1'b1;
  bit          hold_req = 1'b0;
  int          items_sent = 0;
  int          stray_sent = 0;
  int          idle_run = 0;

  message_frame_validator_core i_dut (.*);

  mfv_frame_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Verdict side: random stall bursts, plus one long hold on request
  initial begin
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  // Abort when nothing moves on any channel for too long
  initial begin
    while (idle_run < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready))
        idle_run = 0;
      else
        idle_run++;
    end
    $display("Timeout with %0d verdicts still expected", pending);
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [31:0] nonzero_mask();
    return $urandom_range(1, 32'hFFFF_FFFF);
  endfunction

  // Offer one item and hold it until the transfer; valid stays high after
  task automatic send_item(logic c, logic [31:0] m, logic [31:0] d, logic [31:0] s,
                           logic [15:0] fl, logic [7:0] b);
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    cmd                 = c;
    header_start_marker = m;
    declared_size       = d;
    sender_checksum     = s;
    frame_length        = fl;
    body_byte           = b;
    in_valid            = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  // Write one register; valid stays high for a following write
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Drain the block, then load a new register setting
  task automatic set_config(logic [31:0] s, logic [31:0] e, logic [7:0] h, bit poke_spare);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    write_reg(REG_START_MAGIC, s);
    write_reg(REG_END_MAGIC, e);
    write_reg(REG_HEADER_LENGTH, {24'($urandom), h});
    if (poke_spare) write_reg(REG_SPARE, $urandom);
    cfg_valid = 1'b0;
    cur_start = s;
    cur_end   = e;
    cur_hlen  = h;
  endtask

  // Send a whole frame with correct markers, size and checksum unless a fault is asked for
  task automatic send_frame(int pay_len, logic [3:0] faults);
    logic [7:0]  pay[$];
    logic [31:0] sum;
    logic [31:0] marker;
    logic [31:0] dsize;
    logic [31:0] ssum;
    logic [31:0] tail;
    logic [15:0] flen;
    logic [7:0]  b;
    sum = '0;
    for (int i = 0; i < pay_len; i++) begin
      b = 8'($urandom);
      pay.push_back(b);
      sum = {sum[30:0], sum[31]} + {24'd0, b};
    end
    flen   = 16'(cur_hlen) + 16'(pay_len) + 16'd4;
    marker = ((faults & FAULT_START) != 0) ? cur_start ^ nonzero_mask() : cur_start;
    dsize  = {16'd0, flen};
    if ((faults & FAULT_SIZE) != 0)
      dsize = dsize ^ (($urandom_range(0, 1) == 1) ? 32'h0001_0000 : nonzero_mask());
    tail   = ((faults & FAULT_END) != 0) ? cur_end ^ nonzero_mask() : cur_end;
    ssum   = ((faults & FAULT_SUM) != 0) ? sum ^ nonzero_mask() : sum;
    send_item(CMD_HEADER, marker, dsize, ssum, flen, 8'($urandom));
    for (int i = 0; i < pay_len + 4; i++) begin
      b = (i < pay_len) ? pay[i] : tail[8*(i-pay_len) +: 8];
      send_item(CMD_BODY, $urandom, $urandom, $urandom, 16'($urandom), b);
    end
  endtask

  // Mostly whole frames, some with faults; the rest short headers, cut frames and noise
  task automatic run_random(int n);
    int         target;
    int         pick;
    int         k;
    int         pay_len;
    logic [3:0] faults;
    target = items_sent - stray_sent + n;
    while (items_sent - stray_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        pay_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                              : $urandom_range(0, 12);
        for (int i = 0; i < 4; i++) faults[i] = ($urandom_range(0, 6) == 0);
        send_frame(pay_len, faults);
      end else if (pick < 72) begin
        send_item(CMD_HEADER, $urandom, $urandom, $urandom,
                  16'($urandom_range(0, int'(cur_hlen) + 3)), 8'($urandom));
      end else if (pick < 84) begin
        // Open a frame of random length and leave it before the end marker
        send_item(CMD_HEADER, ($urandom_range(0, 1) == 1) ? cur_start : $urandom,
                  $urandom, $urandom, 16'($urandom), 8'($urandom));
        k = $urandom_range(0, 3);
        repeat (k) send_item(CMD_BODY, $urandom, $urandom, $urandom, 16'($urandom),
                             8'($urandom));
      end else begin
        k = $urandom_range(1, 3);
        repeat (k) send_item(CMD_BODY, $urandom, $urandom, $urandom, 16'($urandom),
                             8'($urandom));
        stray_sent += k;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, reset register values
    send_item(CMD_BODY, '1, '1, '1, '1, 8'hFF);
    send_item(CMD_HEADER, '0, '0, '0, 16'd0, 8'd0);
    send_item(CMD_HEADER, '1, '1, '1, 16'(cur_hlen) + 16'd3, 8'hFF);
    send_frame(0, 4'b0000);
    send_frame(1, FAULT_START | FAULT_SIZE);
    send_item(CMD_HEADER, '1, '1, '1, 16'hFFFF, 8'h00);
    send_item(CMD_BODY, '0, '0, '0, '0, 8'hFF);
    send_item(CMD_BODY, '1, '1, '1, '1, 8'h00);
    send_frame(2, FAULT_END | FAULT_SUM);

    // Largest header length, all-ones markers
    set_config('1, '1, 8'd255, 1'b0);
    run_random(PHASE_ITEMS);

    // Zero header length; stall verdicts long enough to back up the input
    set_config($urandom, $urandom, 8'd0, 1'b1);
    hold_req = 1'b1;
    repeat (24) send_item(CMD_HEADER, $urandom, $urandom, $urandom,
                          16'($urandom_range(0, int'(cur_hlen) + 3)), 8'($urandom));
    run_random(PHASE_ITEMS);

    set_config($urandom, $urandom, 8'($urandom_range(1, 40)), 1'b0);
    run_random(PHASE_ITEMS);

    // Last stretch at full rate on both sides
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    set_config($urandom, '0, HEADER_LENGTH_RESET, 1'b0);
    run_random(PHASE_ITEMS);

    // Wait out outstanding verdicts and any late extra result
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2 * DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d items (%0d noise bytes) over five register settings; %0d verdicts checked",
             items_sent, stray_sent, verdict_count);
    $display("Status codes seen, short down to ok: %b", status_seen);
    if (fail_count == 0 && pending == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
